// ===== hw/rtl/ircft_pkg.sv =====
package ircft_pkg;

  localparam logic [15:0] HEADER_PERIOD = 16'd304;
  localparam logic [15:0] HEADER_HIGH   = 16'd152;
  localparam logic [15:0] BIT_PERIOD    = 16'd76;
  localparam logic [15:0] ONE_HIGH      = 16'd48;
  localparam logic [15:0] ZERO_HIGH     = 16'd24;
  localparam logic [15:0] HOLDOFF_TICKS = 16'd152;

  localparam int          NumSym  = 34;
  localparam logic [5:0]  NUM_SYM = 6'(NumSym);

  // register indexes on the config port
  localparam logic [2:0] REG_MAX_THROTTLE = 3'd0;
  localparam logic [2:0] REG_MAX_TRIM     = 3'd1;
  localparam logic [2:0] REG_BASE_CENTER  = 3'd2;
  localparam logic [2:0] REG_BASE_FB      = 3'd3;
  localparam logic [2:0] REG_BASE_LR      = 3'd4;
  localparam logic [2:0] REG_BASE_DIAG    = 3'd5;
  localparam logic [2:0] REG_GAP_TICKS    = 3'd6;

  // direction codes
  localparam logic [3:0] DIR_C  = 4'd0;
  localparam logic [3:0] DIR_F  = 4'd1;
  localparam logic [3:0] DIR_B  = 4'd2;
  localparam logic [3:0] DIR_L  = 4'd3;
  localparam logic [3:0] DIR_R  = 4'd4;
  localparam logic [3:0] DIR_FR = 4'd5;
  localparam logic [3:0] DIR_FL = 4'd6;
  localparam logic [3:0] DIR_BR = 4'd7;
  localparam logic [3:0] DIR_BL = 4'd8;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  typedef enum logic [2:0] {
    SYM_HDR  = 3'b001,
    SYM_ZERO = 3'b010,
    SYM_ONE  = 3'b100
  } sym_e;

  typedef struct packed {
    logic [15:0] gap_ticks;
    logic [7:0]  base_diag;
    logic [7:0]  base_lr;
    logic [7:0]  base_fb;
    logic [7:0]  base_center;
    logic [5:0]  max_trim;
    logic [6:0]  max_throttle;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gap_ticks:    16'd1000,
    base_diag:    8'd0,
    base_lr:      8'd0,
    base_fb:      8'd0,
    base_center:  8'd0,
    max_trim:     6'd63,
    max_throttle: 7'd127
  };

  typedef struct packed {
    logic [3:0] direction;
    logic [5:0] trim;
    logic [6:0] throttle;
    logic       command;
  } item_t;

  typedef struct packed {
    logic [5:0] symbol_index;
    logic       sending;
    logic       led_level;
  } res_t;

  // Frame as one bit per symbol; symbol 0 is always the header, so its bit is unused.
  function automatic logic [NumSym-1:0] build_frame(logic [6:0] thr, logic [5:0] trm,
                                                    logic [3:0] dir, cfg_t cfg);
    logic [6:0]        t;
    logic [5:0]        r;
    logic [7:0]        dirbits;
    logic [7:0]        base;
    logic [7:0]        diff;
    logic [7:0]        chk;
    logic              lr;
    logic              fb;
    logic [NumSym-1:0] f;
    t = (thr > cfg.max_throttle) ? cfg.max_throttle : thr;
    r = (trm > cfg.max_trim) ? cfg.max_trim : trm;
    diff = {1'b0, cfg.max_throttle - t} + {2'b00, cfg.max_trim - r};
    unique case (dir)
      DIR_F:   begin dirbits = 8'h0F; lr = 1'b1; fb = 1'b0; base = cfg.base_fb;   end
      DIR_B:   begin dirbits = 8'h0F; lr = 1'b1; fb = 1'b1; base = cfg.base_fb;   end
      DIR_L:   begin dirbits = 8'hF0; lr = 1'b1; fb = 1'b1; base = cfg.base_lr;   end
      DIR_R:   begin dirbits = 8'hF0; lr = 1'b0; fb = 1'b1; base = cfg.base_lr;   end
      DIR_FR:  begin dirbits = 8'hFF; lr = 1'b0; fb = 1'b0; base = cfg.base_diag; end
      DIR_FL:  begin dirbits = 8'hFF; lr = 1'b1; fb = 1'b0; base = cfg.base_diag; end
      DIR_BR:  begin dirbits = 8'hFF; lr = 1'b1; fb = 1'b1; base = cfg.base_diag; end
      DIR_BL:  begin dirbits = 8'hFF; lr = 1'b0; fb = 1'b1; base = cfg.base_diag; end
      default: begin dirbits = 8'h00; lr = 1'b1; fb = 1'b1; base = cfg.base_center; end
    endcase
    chk = base - diff;
    f = '0;
    for (int i = 0; i < 7; i++) f[8-i] = t[i];
    for (int i = 0; i < 8; i++) f[16-i] = dirbits[i];
    f[17] = lr;
    f[18] = fb;
    for (int i = 0; i < 6; i++) f[24-i] = r[i];
    f[26] = 1'b1;
    for (int i = 0; i < 6; i++) f[32-i] = chk[i];
    f[33] = 1'b1;
    return f;
  endfunction

  localparam logic [NumSym-1:0] FRAME_RESET = build_frame(7'd1, 6'd0, DIR_C, CFG_RESET);

endpackage

// ===== hw/rtl/ircft_cfg_regs.sv =====
module ircft_cfg_regs
  import ircft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_THROTTLE: cfg_d.max_throttle = cfg_wdata_i[6:0];
        REG_MAX_TRIM:     cfg_d.max_trim     = cfg_wdata_i[5:0];
        REG_BASE_CENTER:  cfg_d.base_center  = cfg_wdata_i[7:0];
        REG_BASE_FB:      cfg_d.base_fb      = cfg_wdata_i[7:0];
        REG_BASE_LR:      cfg_d.base_lr      = cfg_wdata_i[7:0];
        REG_BASE_DIAG:    cfg_d.base_diag    = cfg_wdata_i[7:0];
        REG_GAP_TICKS:    cfg_d.gap_ticks    = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ircft_frame_builder.sv =====
module ircft_frame_builder
  import ircft_pkg::*;
(
  input  item_t             item_i,
  input  cfg_t              cfg_i,
  output logic [NumSym-1:0] frame_o
);

  assign frame_o = build_frame(item_i.throttle, item_i.trim, item_i.direction, cfg_i);

endmodule

// ===== hw/rtl/ircft_tx_engine.sv =====
module ircft_tx_engine
  import ircft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  input  cfg_t              cfg_i,
  input  logic [NumSym-1:0] new_frame_i,
  output res_t              res_o
);

  logic [15:0]       tick_q, tick_d;
  logic              sending_q, sending_d;
  logic [5:0]        pos_q, pos_d;
  sym_e              kind_q, kind_d;
  logic              led_q, led_d;
  logic [NumSym-1:0] frame_q, frame_d;
  logic              pend_vld_q, pend_vld_d;
  logic [NumSym-1:0] pend_q, pend_d;

  logic [15:0] tick_inc;
  logic [15:0] hold_lim;
  logic [15:0] high_lim;
  logic [15:0] period_lim;
  logic [5:0]  pos_inc;

  assign tick_inc = tick_q + 16'd1;
  assign pos_inc  = pos_q + 6'd1;
  assign hold_lim = (cfg_i.gap_ticks > HOLDOFF_TICKS) ? cfg_i.gap_ticks - HOLDOFF_TICKS : '0;

  always_comb begin
    unique case (kind_q)
      SYM_ONE:  begin high_lim = ONE_HIGH;    period_lim = BIT_PERIOD;    end
      SYM_ZERO: begin high_lim = ZERO_HIGH;   period_lim = BIT_PERIOD;    end
      default:  begin high_lim = HEADER_HIGH; period_lim = HEADER_PERIOD; end
    endcase
  end

  always_comb begin
    tick_d     = tick_q;
    sending_d  = sending_q;
    pos_d      = pos_q;
    kind_d     = kind_q;
    led_d      = led_q;
    frame_d    = frame_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    if (step_i) begin
      if (item_i.command == CMD_SET) begin
        if (sending_q) begin
          pend_d     = new_frame_i;
          pend_vld_d = 1'b1;
        end else begin
          // set while idle may lengthen the remaining gap: the counter is clamped to gap minus hold-off
          if (tick_q > hold_lim) tick_d = hold_lim;
          frame_d = new_frame_i;
        end
      end else if (!sending_q) begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.gap_ticks) begin
          sending_d = 1'b1;
          tick_d    = '0;
          pos_d     = '0;
          kind_d    = SYM_HDR;
        end
      end else if (tick_inc <= high_lim) begin
        tick_d = tick_inc;
        led_d  = ~led_q;
      end else if (tick_inc <= period_lim) begin
        tick_d = tick_inc;
        led_d  = 1'b0;
      end else begin
        tick_d = '0;
        if (pos_inc >= NUM_SYM) begin
          pos_d     = NUM_SYM;
          sending_d = 1'b0;
          if (pend_vld_q) begin
            frame_d    = pend_q;
            pend_vld_d = 1'b0;
          end
        end else begin
          pos_d  = pos_inc;
          kind_d = frame_q[pos_inc] ? SYM_ONE : SYM_ZERO;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      sending_q  <= 1'b0;
      pos_q      <= '0;
      kind_q     <= SYM_HDR;
      led_q      <= 1'b0;
      frame_q    <= FRAME_RESET;
      pend_vld_q <= 1'b0;
    end else begin
      tick_q     <= tick_d;
      sending_q  <= sending_d;
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      led_q      <= led_d;
      frame_q    <= frame_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  assign res_o.led_level    = led_d;
  assign res_o.sending      = sending_d;
  assign res_o.symbol_index = pos_d;

endmodule

// ===== hw/rtl/ir_control_frame_transmitter.sv =====
// Infrared remote-control frame transmitter. Each input item is either a timer
// tick (tuser 0) or a set command (tuser 1) carrying throttle, trim and direction;
// every item yields exactly one result item with the LED level, the sending flag
// and the current symbol index as they stand after that item. One item is taken
// per clock cycle unless m_axis_tready holds the output; each item passes from the
// input register through the tick/frame update into the result register.
// A set command during a frame is held and takes effect when the frame ends.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i and
// must only change while no item is in flight.
module ir_control_frame_transmitter
  import ircft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // throttle[6:0], trim[12:7], direction[16:13], zero pad
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // led_level[0], sending[1], symbol_index[7:2]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t              cfg;
  item_t             in_item_q;
  logic              in_vld_q;
  logic              out_vld_q;
  res_t              out_res_q;
  res_t              eng_res;
  logic [NumSym-1:0] new_frame;
  logic              advance;
  logic              s_accept;

  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.command   <= s_axis_tuser;
      in_item_q.throttle  <= s_axis_tdata[6:0];
      in_item_q.trim      <= s_axis_tdata[12:7];
      in_item_q.direction <= s_axis_tdata[16:13];
    end
    if (advance) begin
      out_res_q <= eng_res;
    end
  end

  ircft_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ircft_frame_builder u_build (
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .frame_o (new_frame)
  );

  ircft_tx_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .new_frame_i (new_frame),
    .res_o       (eng_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_res_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ircft_pkg::*;

  localparam int FrameBits = 3 * NumSym;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // throttle[6:0], trim[12:7], direction[16:13], zero pad
  logic        s_axis_tuser = 1'b0; // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // led_level[0], sending[1], symbol_index[7:2]
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  ir_control_frame_transmitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t tx_items[$];
  res_t  status_due[$];
  int    error_count = 0;
  int    results_seen = 0;

  // transmitter state as the block should hold it
  cfg_t                 shadow_cfg;
  logic [15:0]          tick_cnt;
  logic [15:0]          period_lim;
  logic [15:0]          high_lim;
  logic                 tx_active;
  logic                 led;
  logic [5:0]           sym_pos;
  logic [FrameBits-1:0] frame_syms;
  logic                 held_valid;
  logic [FrameBits-1:0] held_frame;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    error_count++;
  endtask

  function automatic logic [2:0] sym_code(input logic b);
    return b ? SYM_ONE : SYM_ZERO;
  endfunction

  // three-bit symbol code per slot, slot 0 in the low bits
  function automatic logic [FrameBits-1:0] encode_frame(input logic [6:0] thr,
                                                        input logic [5:0] trm,
                                                        input logic [3:0] dir);
    logic [6:0]           t;
    logic [5:0]           r;
    logic [7:0]           pattern;
    logic [7:0]           base;
    logic [7:0]           shortfall;
    logic [7:0]           chk;
    logic                 left_f;
    logic                 back_f;
    logic [FrameBits-1:0] f;
    int                   i;
    t = (thr > shadow_cfg.max_throttle) ? shadow_cfg.max_throttle : thr;
    r = (trm > shadow_cfg.max_trim) ? shadow_cfg.max_trim : trm;
    shortfall = 8'(shadow_cfg.max_throttle - t) + 8'(shadow_cfg.max_trim - r);
    left_f = 1'b1;
    back_f = 1'b1;
    case (dir)
      DIR_F: begin
        pattern = 8'h0F; back_f = 1'b0; base = shadow_cfg.base_fb;
      end
      DIR_B: begin
        pattern = 8'h0F; base = shadow_cfg.base_fb;
      end
      DIR_L: begin
        pattern = 8'hF0; base = shadow_cfg.base_lr;
      end
      DIR_R: begin
        pattern = 8'hF0; left_f = 1'b0; base = shadow_cfg.base_lr;
      end
      DIR_FR: begin
        pattern = 8'hFF; left_f = 1'b0; back_f = 1'b0; base = shadow_cfg.base_diag;
      end
      DIR_FL: begin
        pattern = 8'hFF; back_f = 1'b0; base = shadow_cfg.base_diag;
      end
      DIR_BR: begin
        pattern = 8'hFF; base = shadow_cfg.base_diag;
      end
      DIR_BL: begin
        pattern = 8'hFF; left_f = 1'b0; base = shadow_cfg.base_diag;
      end
      default: begin
        pattern = 8'h00; base = shadow_cfg.base_center;
      end
    endcase
    chk = base - shortfall;  // only the low six bits are sent
    f[0 +: 3] = SYM_HDR;
    f[3 +: 3] = SYM_ZERO;
    for (i = 0; i < 7; i++) f[3 * (8 - i) +: 3] = sym_code(t[i]);
    for (i = 0; i < 8; i++) f[3 * (16 - i) +: 3] = sym_code(pattern[i]);
    f[3 * 17 +: 3] = sym_code(left_f);
    f[3 * 18 +: 3] = sym_code(back_f);
    for (i = 0; i < 6; i++) f[3 * (24 - i) +: 3] = sym_code(r[i]);
    f[3 * 25 +: 3] = SYM_ZERO;
    f[3 * 26 +: 3] = SYM_ONE;
    for (i = 0; i < 6; i++) f[3 * (32 - i) +: 3] = sym_code(chk[i]);
    f[3 * 33 +: 3] = SYM_ONE;
    return f;
  endfunction

  task automatic reset_model();
    shadow_cfg = CFG_RESET;
    tick_cnt   = '0;
    period_lim = '0;
    high_lim   = '0;
    tx_active  = 1'b0;
    led        = 1'b0;
    sym_pos    = '0;
    held_valid = 1'b0;
    held_frame = '0;
    frame_syms = encode_frame(7'd1, 6'd0, DIR_C);
  endtask

  task automatic advance_transmitter(input item_t it, output res_t st);
    logic [15:0] lim;
    logic [2:0]  sym;
    if (it.command == CMD_SET) begin
      if (tx_active) begin
        held_frame = encode_frame(it.throttle, it.trim, it.direction);
        held_valid = 1'b1;
      end else begin
        lim = (shadow_cfg.gap_ticks > HOLDOFF_TICKS) ? shadow_cfg.gap_ticks - HOLDOFF_TICKS
                                                     : 16'd0;
        if (tick_cnt > lim) tick_cnt = lim;
        frame_syms = encode_frame(it.throttle, it.trim, it.direction);
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (!tx_active) begin
        if (tick_cnt >= shadow_cfg.gap_ticks) begin
          // frame start leaves the LED where it was
          tx_active  = 1'b1;
          tick_cnt   = '0;
          sym_pos    = '0;
          period_lim = HEADER_PERIOD;
          high_lim   = HEADER_HIGH;
        end
      end else if (tick_cnt <= high_lim) begin
        led = ~led;
      end else if (tick_cnt <= period_lim) begin
        led = 1'b0;
      end else begin
        sym_pos  = sym_pos + 6'd1;
        tick_cnt = '0;
        if (sym_pos >= NUM_SYM) begin
          sym_pos   = NUM_SYM;
          tx_active = 1'b0;
          if (held_valid) begin
            frame_syms = held_frame;
            held_valid = 1'b0;
          end
        end else begin
          sym = frame_syms[3 * sym_pos +: 3];
          if (sym == SYM_ONE) begin
            period_lim = BIT_PERIOD;
            high_lim   = ONE_HIGH;
          end else if (sym == SYM_ZERO) begin
            period_lim = BIT_PERIOD;
            high_lim   = ZERO_HIGH;
          end else begin
            period_lim = HEADER_PERIOD;
            high_lim   = HEADER_HIGH;
          end
        end
      end
    end
    st.led_level    = led;
    st.sending      = tx_active;
    st.symbol_index = sym_pos;
  endtask

  // sender side
  int    idle_left = 0;
  int    steady_items = 0;
  item_t offered;

  function automatic int pick_gap();
    int roll;
    if (steady_items > 0) begin
      steady_items--;
      return 0;
    end
    roll = $urandom_range(999);
    if (roll < 10) begin
      steady_items = $urandom_range(300, 50);
      return 0;
    end
    if (roll < 30) return $urandom_range(40, 8);
    if (roll < 350) return $urandom_range(3, 1);
    return 0;
  endfunction

  always @(posedge clk_i) begin
    res_t st;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_transmitter(offered, st);
        status_due.push_back(st);
        idle_left = pick_gap();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (idle_left > 0) begin
          idle_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tx_items.size() > 0) begin
          offered = tx_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, offered.direction, offered.trim, offered.throttle};
          s_axis_tuser  <= offered.command;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  int hold_left = 0;
  int open_left = 0;
  bit pressure_done = 1'b0;

  always @(posedge clk_i) begin
    int roll;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!pressure_done && results_seen >= 400) begin
      // long hold-off: the sender keeps offering until the block backs up
      pressure_done = 1'b1;
      hold_left = 299;
      m_axis_tready <= 1'b0;
    end else if (open_left > 0) begin
      open_left--;
      m_axis_tready <= 1'b1;
    end else begin
      roll = $urandom_range(999);
      if (roll < 8) begin
        open_left = $urandom_range(300, 50);
        m_axis_tready <= 1'b1;
      end else if (roll < 25) begin
        hold_left = $urandom_range(40, 8) - 1;
        m_axis_tready <= 1'b0;
      end else if (roll < 300) begin
        hold_left = $urandom_range(3, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (status_due.size() == 0) begin
        report_mismatch("result with no item pending", int'(got), 0);
      end else begin
        want = status_due.pop_front();
        if (got.led_level !== want.led_level)
          report_mismatch("led_level", got.led_level, want.led_level);
        if (got.sending !== want.sending)
          report_mismatch("sending", got.sending, want.sending);
        if (got.symbol_index !== want.symbol_index)
          report_mismatch("symbol_index", got.symbol_index, want.symbol_index);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAX_THROTTLE: shadow_cfg.max_throttle = val[6:0];
      REG_MAX_TRIM:     shadow_cfg.max_trim     = val[5:0];
      REG_BASE_CENTER:  shadow_cfg.base_center  = val[7:0];
      REG_BASE_FB:      shadow_cfg.base_fb      = val[7:0];
      REG_BASE_LR:      shadow_cfg.base_lr      = val[7:0];
      REG_BASE_DIAG:    shadow_cfg.base_diag    = val[7:0];
      REG_GAP_TICKS:    shadow_cfg.gap_ticks    = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_MAX_THROTTLE, 16'(c.max_throttle));
    write_reg(REG_MAX_TRIM,     16'(c.max_trim));
    write_reg(REG_BASE_CENTER,  16'(c.base_center));
    write_reg(REG_BASE_FB,      16'(c.base_fb));
    write_reg(REG_BASE_LR,      16'(c.base_lr));
    write_reg(REG_BASE_DIAG,    16'(c.base_diag));
    write_reg(REG_GAP_TICKS,    c.gap_ticks);
  endtask

  task automatic queue_set(input logic [6:0] thr, input logic [5:0] trm,
                           input logic [3:0] dir);
    item_t it;
    it.command   = CMD_SET;
    it.throttle  = thr;
    it.trim      = trm;
    it.direction = dir;
    tx_items.push_back(it);
  endtask

  function automatic logic [6:0] pick_throttle();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 7'd0;
    if (roll == 1) return 7'd127;
    return 7'($urandom_range(127));
  endfunction

  function automatic logic [5:0] pick_trim();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 6'd0;
    if (roll == 1) return 6'd63;
    return 6'($urandom_range(63));
  endfunction

  // mostly ticks; sets come alone or in short bursts so some overwrite a held frame
  task automatic queue_random(input int n);
    item_t it;
    int    i;
    int    burst;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(999) < 12) begin
        burst = ($urandom_range(4) == 0) ? $urandom_range(3, 2) : 1;
        repeat (burst)
          queue_set(pick_throttle(), pick_trim(),
                    ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                             : 4'($urandom_range(8)));
      end else begin
        // payload of a tick is ignored by the block; vary it anyway
        it = item_t'($urandom);
        it.command = CMD_TICK;
        tx_items.push_back(it);
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (tx_items.size() != 0 || s_axis_tvalid || status_due.size() != 0);
  endtask

  initial begin
    cfg_t c;
    item_t tk;
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every direction, out-of-range directions
    queue_set(7'd127, 6'd63, DIR_C);
    queue_set(7'd0, 6'd0, DIR_BL);
    queue_set(7'd1, 6'd0, DIR_C);
    queue_set(7'd85, 6'd42, DIR_F);
    queue_set(7'd42, 6'd21, DIR_B);
    queue_set(7'd127, 6'd0, DIR_L);
    queue_set(7'd0, 6'd63, DIR_R);
    queue_set(7'd100, 6'd10, DIR_FR);
    queue_set(7'd64, 6'd32, DIR_FL);
    queue_set(7'd63, 6'd31, DIR_BR);
    queue_set(7'd127, 6'd0, 4'd9);
    queue_set(7'd0, 6'd63, 4'd15);
    queue_set(7'd5, 6'd7, 4'd12);
    tk = '0;
    tk.command = CMD_TICK;
    repeat (4) tx_items.push_back(tk);
    queue_set(7'd120, 6'd50, DIR_FR);
    queue_random(150);
    drain();

    // all maximums and bases high; gap below the hold-off
    c = '{gap_ticks: 16'd150, base_diag: 8'd255, base_lr: 8'd255, base_fb: 8'd255,
          base_center: 8'd255, max_trim: 6'd63, max_throttle: 7'd127};
    apply_settings(c);
    queue_random(250);
    drain();

    // all clamps closed, one-tick gap
    c = '{gap_ticks: 16'd1, base_diag: 8'd0, base_lr: 8'd0, base_fb: 8'd0,
          base_center: 8'd0, max_trim: 6'd0, max_throttle: 7'd0};
    apply_settings(c);
    queue_random(250);
    drain();

    // random clamps and bases, zero gap
    c.max_throttle = 7'($urandom_range(127));
    c.max_trim     = 6'($urandom_range(63));
    c.base_center  = 8'($urandom_range(255));
    c.base_fb      = 8'($urandom_range(255));
    c.base_lr      = 8'($urandom_range(255));
    c.base_diag    = 8'($urandom_range(255));
    c.gap_ticks    = 16'd0;
    apply_settings(c);
    queue_random(250);
    drain();

    c.max_throttle = 7'($urandom_range(126, 1));
    c.max_trim     = 6'($urandom_range(62, 1));
    c.base_center  = 8'($urandom_range(255));
    c.base_fb      = 8'($urandom_range(255));
    c.base_lr      = 8'($urandom_range(255));
    c.base_diag    = 8'($urandom_range(255));
    c.gap_ticks    = 16'($urandom_range(700, 153));
    apply_settings(c);
    queue_random(200);
    drain();

    // longest gap: no new frame starts; sets while idle clamp the counter and load the frame
    c.max_throttle = 7'd127;
    c.max_trim     = 6'd0;
    c.gap_ticks    = 16'd65535;
    apply_settings(c);
    queue_random(80);
    drain();

    repeat (20) @(posedge clk_i);
    if (status_due.size() != 0) report_mismatch("results missing", 0, status_due.size());
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ircft_pkg.sv
hw/rtl/ircft_cfg_regs.sv
hw/rtl/ircft_frame_builder.sv
hw/rtl/ircft_tx_engine.sv
hw/rtl/ir_control_frame_transmitter.sv
test/testbench.sv
